@@ sv/atm_cell_admission_epd_fba_core_defines.svh @@
// assertion macros used by the checker file
// depends on nothing
`ifndef ATM_CELL_ADMISSION_EPD_FBA_CORE_DEFINES_SVH
`define ATM_CELL_ADMISSION_EPD_FBA_CORE_DEFINES_SVH
`define ACA_ASSERT_IMPL(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("violation");
`define ACA_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("violation");
`endif

@@ sv/aca_epd_pkg.sv @@
// types and constants of the atm admission block
// depends on nothing
package aca_epd_pkg;
   localparam int CntW = 13;
   localparam logic [CntW-1:0] CntMax = 13'h1FFF;

   typedef enum logic [1:0] {
      OP_ARRIVE = 2'd0,
      OP_DEPART = 2'd1,
      OP_LIMIT  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      REG_BUFFER_LIMIT = 3'd0,
      REG_EPD_THRESHOLD = 3'd1,
      REG_CLP1_THRESHOLD = 3'd2,
      REG_EPD_FOR_CLP1 = 3'd3,
      REG_FAIR_MODE = 3'd4,
      REG_DELIVER_EOF = 3'd5
   } reg_type;

   localparam logic [1:0] CauseNone = 2'd0;
   localparam logic [1:0] CausePolicy = 2'd1;
   localparam logic [1:0] CauseOverflow = 2'd2;

   localparam logic [1:0] FairClp0 = 2'd1;
   localparam logic [1:0] FairFba = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

   typedef struct packed {
      logic [12:0] vc_frame_limit;
      logic [12:0] vc_clp1_limit;
      logic        end_of_frame;
      logic        loss_priority;
      logic [4:0]  vc_number;
      logic [1:0]  opcode;
   } req_type;

   typedef struct packed {
      logic        underflow_error;
      logic [12:0] vc_queue_length;
      logic [12:0] occupancy;
      logic [1:0]  drop_cause;
      logic        accepted;
   } rsp_type;
endpackage

@@ sv/aca_stream_if.sv @@
// valid/ready channel carrying a packed payload
// depends on nothing
interface aca_stream_if #(parameter int W = 8);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ sv/aca_epd_ctrl.sv @@
// controller: load, execute, hold result until taken
// depends on aca_epd_pkg
module aca_epd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   output logic                 out_valid,
   input  logic                 out_ready,
   output aca_epd_pkg::cmd_type cmd
);
   aca_epd_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= aca_epd_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      in_ready = 1'b0;
      out_valid = 1'b0;
      cmd = '0;
      unique case (state_ff)
         aca_epd_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = aca_epd_pkg::ST_EXEC;
            end
         end
         aca_epd_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = aca_epd_pkg::ST_HOLD;
         end
         aca_epd_pkg::ST_HOLD: begin
            out_valid = 1'b1;
            // accept next item while result leaves
            in_ready = out_ready;
            if (out_ready) begin
               if (in_valid) begin
                  cmd.load = 1'b1;
                  state_in = aca_epd_pkg::ST_EXEC;
               end else state_in = aca_epd_pkg::ST_IDLE;
            end
         end
         default: state_in = aca_epd_pkg::ST_IDLE;
      endcase
   end
endmodule

@@ sv/aca_epd_dp.sv @@
// datapath: per-vc state, thresholds and the frame decision
// depends on aca_epd_pkg
module aca_epd_dp #(
   parameter int NUM_VC = 32,
   parameter int BUFFER_CELLS = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  aca_epd_pkg::cmd_type cmd,
   input  aca_epd_pkg::req_type req,
   input  logic                 csr_write,
   input  logic [2:0]           csr_index,
   input  logic [12:0]          csr_data,
   output aca_epd_pkg::rsp_type rsp
);
   localparam int VcW = (NUM_VC > 1) ? $clog2(NUM_VC) : 1;
   localparam logic [12:0] LimRst = 13'((BUFFER_CELLS - 1) & 8191);
   localparam logic [12:0] Fac5 = 13'(5 * (NUM_VC - 1));

   logic [11:0] buf_lim_ff;
   logic [12:0] epd_th_ff, clp1_th_ff;
   logic epd_clp1_ff, eof_dlv_ff;
   logic [1:0] fair_ff;

   logic [12:0] occ_ff;
   logic [NUM_VC-1:0] start_ff, accf_ff;
   logic [12:0] tot_ff [NUM_VC];
   logic [12:0] clp0_ff [NUM_VC];
   logic [12:0] flim_ff [NUM_VC];
   logic [12:0] clim_ff [NUM_VC];

   aca_epd_pkg::req_type r_ff;
   aca_epd_pkg::rsp_type rsp_ff;
   // first-stage products, registered
   logic [25:0] p1_ff;      // clp0*5*nm1
   logic [12:0] t_ff, c0_ff, fl_ff, cl_ff;
   logic valid_ff;
   logic [41:0] rhs2_ff;

   wire [4:0] vc_w = req.vc_number;
   wire [VcW-1:0] vi = VcW'(vc_w);
   wire in_rng = 32'(vc_w) < NUM_VC;

   // stage 1 on load: read per-vc entries, form products
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         r_ff <= req;
         valid_ff <= in_rng;
         t_ff <= tot_ff[vi];
         c0_ff <= clp0_ff[vi];
         fl_ff <= flim_ff[vi];
         cl_ff <= clim_ff[vi];
         p1_ff <= 26'(clp0_ff[vi]) * 26'(Fac5);
         rhs2_ff <= 42'(4 * 14'(epd_th_ff - clp1_th_ff)) * 42'(occ_ff);
      end
   end

   wire [12:0] x = occ_ff;
   wire arr = r_ff.opcode == aca_epd_pkg::OP_ARRIVE;
   wire dep = r_ff.opcode == aca_epd_pkg::OP_DEPART;
   wire clp = r_ff.loss_priority;
   wire eof = r_ff.end_of_frame;
   wire [VcW-1:0] ri = VcW'(r_ff.vc_number);

   logic ok, facc, acc, under;
   logic [1:0] cause;
   logic [12:0] occ_n, tot_n, c0_n;
   logic [36:0] m1l;
   logic [47:0] m2l;
   logic [42:0] m2r;

   always_comb begin
      m1l = 37'(t_ff) * 37'(Fac5);
      m2l = 48'(p1_ff) * 48'(13'(x - clp1_th_ff));
      m2r = 43'(rhs2_ff);
      ok = 1'b1;
      if (x >= epd_th_ff || t_ff >= fl_ff) ok = 1'b0;
      if (clp && t_ff >= cl_ff) ok = 1'b0;
      if (epd_clp1_ff && clp && x >= clp1_th_ff) ok = 1'b0;
      if (!clp && x >= clp1_th_ff) begin
         if (fair_ff == aca_epd_pkg::FairClp0) begin
            if (m1l > 37'(4 * 15'(epd_th_ff))) ok = 1'b0;
         end else if (fair_ff == aca_epd_pkg::FairFba) begin
            // e-l negative makes rhs <= 0 while lhs >= 0
            if (clp1_th_ff > epd_th_ff) begin
               if (m2l != 0 || x != 0) ok = 1'b0;
               if (m2l == 0 && x == 0) ok = 1'b1 & ok;
            end else if (m2l > 48'(m2r)) ok = 1'b0;
         end
      end
      facc = start_ff[ri] ? ok : accf_ff[ri];
      if (!epd_clp1_ff && clp && x > clp1_th_ff) facc = 1'b0;
      acc = 1'b0;
      cause = aca_epd_pkg::CauseNone;
      under = 1'b0;
      occ_n = occ_ff;
      tot_n = t_ff;
      c0_n = c0_ff;
      if (arr) begin
         if (!valid_ff) cause = aca_epd_pkg::CausePolicy;
         else if (facc || (eof && eof_dlv_ff)) begin
            if (x >= 13'(buf_lim_ff)) begin
               cause = aca_epd_pkg::CauseOverflow;
               facc = 1'b0;
            end else begin
               acc = 1'b1;
               occ_n = (x == aca_epd_pkg::CntMax) ? x : x + 13'd1;
               tot_n = (t_ff == aca_epd_pkg::CntMax) ? t_ff : t_ff + 13'd1;
               if (!clp) c0_n = (c0_ff == aca_epd_pkg::CntMax) ? c0_ff : c0_ff + 13'd1;
            end
         end else cause = aca_epd_pkg::CausePolicy;
      end else if (dep && valid_ff) begin
         if (t_ff == 0) under = 1'b1; else tot_n = t_ff - 13'd1;
         if (!clp) begin
            if (c0_ff == 0) under = 1'b1; else c0_n = c0_ff - 13'd1;
         end
         if (x == 0) under = 1'b1; else occ_n = x - 13'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_lim_ff <= 12'd4095;
         epd_th_ff <= 13'd3072;
         clp1_th_ff <= 13'd2048;
         epd_clp1_ff <= 1'b0;
         fair_ff <= 2'd0;
         eof_dlv_ff <= 1'b0;
         occ_ff <= '0;
         start_ff <= '1;
         accf_ff <= '0;
         for (int i = 0; i < NUM_VC; i++) begin
            tot_ff[i] <= '0;
            clp0_ff[i] <= '0;
            flim_ff[i] <= LimRst;
            clim_ff[i] <= LimRst;
         end
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               aca_epd_pkg::REG_BUFFER_LIMIT: buf_lim_ff <= csr_data[11:0];
               aca_epd_pkg::REG_EPD_THRESHOLD: epd_th_ff <= csr_data;
               aca_epd_pkg::REG_CLP1_THRESHOLD: clp1_th_ff <= csr_data;
               aca_epd_pkg::REG_EPD_FOR_CLP1: epd_clp1_ff <= csr_data[0];
               aca_epd_pkg::REG_FAIR_MODE: fair_ff <= csr_data[1:0];
               aca_epd_pkg::REG_DELIVER_EOF: eof_dlv_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (cmd.exec && valid_ff) begin
            occ_ff <= occ_n;
            tot_ff[ri] <= tot_n;
            clp0_ff[ri] <= c0_n;
            if (arr) begin
               start_ff[ri] <= eof;
               accf_ff[ri] <= facc;
            end
            if (r_ff.opcode == aca_epd_pkg::OP_LIMIT) begin
               flim_ff[ri] <= r_ff.vc_frame_limit;
               clim_ff[ri] <= r_ff.vc_clp1_limit;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_ff.accepted <= acc;
         rsp_ff.drop_cause <= cause;
         rsp_ff.occupancy <= valid_ff ? occ_n : occ_ff;
         rsp_ff.vc_queue_length <= valid_ff ? tot_n : 13'd0;
         rsp_ff.underflow_error <= under;
      end
   end
   assign rsp = rsp_ff;
endmodule

@@ sv/atm_cell_admission_epd_fba_core.sv @@
// Cell admission for a shared ATM buffer with early and partial packet
// discard and fair buffer allocation. The result of an item is offered
// in the hold state, after the execute state; because of the per-vc
// read-modify-write and the registered fairness products, a new item is
// taken only once the previous result is taken. No clearing pass.
module atm_cell_admission_epd_fba_core #(
   parameter int NUM_VC = 32,
   parameter int BUFFER_CELLS = 4096
) (
   input  logic         clock,
   input  logic         reset,
   aca_stream_if.sink   req_ch,
   aca_stream_if.source rsp_ch,
   input  logic         csr_write,
   input  logic [2:0]   csr_index,
   input  logic [12:0]  csr_data
);
   aca_epd_pkg::cmd_type cmd;
   aca_epd_pkg::rsp_type rsp;

   aca_epd_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req_ch.valid), .in_ready(req_ch.ready),
      .out_valid(rsp_ch.valid), .out_ready(rsp_ch.ready),
      .cmd(cmd)
   );

   aca_epd_dp #(.NUM_VC(NUM_VC), .BUFFER_CELLS(BUFFER_CELLS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .req(aca_epd_pkg::req_type'(req_ch.data)),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .rsp(rsp)
   );
   assign rsp_ch.data = rsp;
endmodule

@@ sv/aca_epd_checker.sv @@
// port-level checks on the admission block
// depends on the defines header
`include "atm_cell_admission_epd_fba_core_defines.svh"
module aca_epd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rv, rr, ov, orr,
   input logic [31:0] od
);
   `ACA_ASSERT_IMPL(a_acc_nocause, clock, reset, ov && od[0], od[2:1] == 2'd0)
   `ACA_ASSERT_IMPL(a_cause_range, clock, reset, ov, od[2:1] != 2'd3)
   `ACA_ASSERT_NEXT(a_acc_no_out, clock, reset, rv && rr, !ov)
   `ACA_ASSERT_IMPL(a_hold, clock, reset, ov && !orr, !rr)
endmodule

bind atm_cell_admission_epd_fba_core aca_epd_checker u_chk (
   .clock(clock), .reset(reset), .rv(req_ch.valid), .rr(req_ch.ready),
   .ov(rsp_ch.valid), .orr(rsp_ch.ready), .od(32'(rsp_ch.data)));

@@ dv/tb_atm_cell_admission_epd_fba_core.sv @@
// testbench for the atm cell admission block: directed table, then random
// phases under several register settings, checked against a local predictor
// depends on aca_epd_pkg, aca_stream_if and atm_cell_admission_epd_fba_core
`timescale 1ns / 1ps

module tb_atm_cell_admission_epd_fba_core;
   localparam int NumVc = 32;
   localparam int CycleLimit = 200000;
   localparam int ItemsPerPhase = 70;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = aca_epd_pkg::REG_BUFFER_LIMIT;
   logic [12:0] csr_data = '0;

   aca_stream_if #(.W($bits(aca_epd_pkg::req_type))) req_if ();
   aca_stream_if #(.W($bits(aca_epd_pkg::rsp_type))) rsp_if ();

   atm_cell_admission_epd_fba_core u_dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_if.sink),
      .rsp_ch(rsp_if.source),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   // admission state mirrored by the predictor
   logic [11:0] buf_limit;
   logic [12:0] epd_thr, clp1_thr;
   logic        frame_clp1, deliver_eof;
   logic [1:0]  fair_mode;
   logic [12:0] occ;
   logic        start_flag [NumVc];
   logic        accept_flag [NumVc];
   logic [12:0] total_cnt [NumVc];
   logic [12:0] clp0_cnt [NumVc];
   logic [12:0] frame_lim [NumVc];
   logic [12:0] clp1_lim [NumVc];

   aca_epd_pkg::rsp_type expected_rsp [$];
   int errors = 0;
   int cycles = 0;
   logic typed_valid = 1'b0;
   aca_epd_pkg::rsp_type typed_rsp;
   logic burst = 1'b0;

   function automatic logic [12:0] sat_inc(logic [12:0] v);
      return (v == aca_epd_pkg::CntMax) ? v : v + 13'd1;
   endfunction

   function automatic logic frame_admit(int vc, logic clp);
      longint x, l, e, lhs, rhs;
      logic ok;
      x = occ;
      l = clp1_thr;
      e = epd_thr;
      ok = 1'b1;
      if (occ >= epd_thr || total_cnt[vc] >= frame_lim[vc]) ok = 1'b0;
      if (clp && total_cnt[vc] >= clp1_lim[vc]) ok = 1'b0;
      if (frame_clp1 && clp && occ >= clp1_thr) ok = 1'b0;
      if (!clp && occ >= clp1_thr) begin
         if (fair_mode == aca_epd_pkg::FairClp0) begin
            lhs = 5 * longint'(total_cnt[vc]) * (NumVc - 1);
            if (lhs > 4 * e) ok = 1'b0;
         end else if (fair_mode == aca_epd_pkg::FairFba) begin
            lhs = 5 * longint'(clp0_cnt[vc]) * (NumVc - 1) * (x - l);
            rhs = 4 * (e - l) * x;
            if (lhs > rhs) ok = 1'b0;
         end
      end
      return ok;
   endfunction

   function automatic aca_epd_pkg::rsp_type admit_cell(aca_epd_pkg::req_type r);
      aca_epd_pkg::rsp_type o;
      int vc;
      vc = r.vc_number;
      o = '0;
      case (aca_epd_pkg::op_type'(r.opcode))
         aca_epd_pkg::OP_ARRIVE: begin
            if (start_flag[vc]) begin
               start_flag[vc] = 1'b0;
               accept_flag[vc] = frame_admit(vc, r.loss_priority);
            end
            if (r.end_of_frame) start_flag[vc] = 1'b1;
            // per-cell clp1 discard cuts the rest of the frame
            if (!frame_clp1 && r.loss_priority && occ > clp1_thr) accept_flag[vc] = 1'b0;
            if (accept_flag[vc] || (r.end_of_frame && deliver_eof)) begin
               if (occ >= buf_limit) begin
                  o.drop_cause = aca_epd_pkg::CauseOverflow;
                  accept_flag[vc] = 1'b0;
               end else begin
                  o.accepted = 1'b1;
                  occ = sat_inc(occ);
                  total_cnt[vc] = sat_inc(total_cnt[vc]);
                  if (!r.loss_priority) clp0_cnt[vc] = sat_inc(clp0_cnt[vc]);
               end
            end else begin
               o.drop_cause = aca_epd_pkg::CausePolicy;
            end
         end
         aca_epd_pkg::OP_DEPART: begin
            if (total_cnt[vc] == 0) o.underflow_error = 1'b1;
            else total_cnt[vc] = total_cnt[vc] - 13'd1;
            if (!r.loss_priority) begin
               if (clp0_cnt[vc] == 0) o.underflow_error = 1'b1;
               else clp0_cnt[vc] = clp0_cnt[vc] - 13'd1;
            end
            if (occ == 0) o.underflow_error = 1'b1;
            else occ = occ - 13'd1;
         end
         aca_epd_pkg::OP_LIMIT: begin
            frame_lim[vc] = r.vc_frame_limit;
            clp1_lim[vc] = r.vc_clp1_limit;
         end
         default: ;
      endcase
      o.occupancy = occ;
      o.vc_queue_length = total_cnt[vc];
      return o;
   endfunction

   function automatic aca_epd_pkg::req_type mk_req(aca_epd_pkg::op_type op, int vc,
                                                   logic clp, logic eof,
                                                   logic [12:0] flim = 13'd0,
                                                   logic [12:0] clim = 13'd0);
      aca_epd_pkg::req_type r;
      r.opcode = op;
      r.vc_number = 5'(vc);
      r.loss_priority = clp;
      r.end_of_frame = eof;
      r.vc_frame_limit = flim;
      r.vc_clp1_limit = clim;
      return r;
   endfunction

   function automatic aca_epd_pkg::rsp_type mk_rsp(logic acc, logic [1:0] cause, int o,
                                                   int q, logic u);
      aca_epd_pkg::rsp_type s;
      s.accepted = acc;
      s.drop_cause = cause;
      s.occupancy = 13'(o);
      s.vc_queue_length = 13'(q);
      s.underflow_error = u;
      return s;
   endfunction

   function automatic logic [12:0] rand_limit();
      case ($urandom_range(0, 9))
         0: return 13'd0;
         1: return 13'h1FFF;
         2: return 13'($urandom_range(0, 8191));
         default: return 13'($urandom_range(1, 40));
      endcase
   endfunction

   // mostly a few busy vcs, balanced arrivals and departures near the limits
   function automatic aca_epd_pkg::req_type rand_req();
      int vc, pick, arrive_pct;
      logic clp;
      vc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 5);
      pick = $urandom_range(0, 99);
      arrive_pct = (occ < buf_limit + 4 && occ < 60) ? 60 : 30;
      if (pick < arrive_pct)
         return mk_req(aca_epd_pkg::OP_ARRIVE, vc, $urandom_range(0, 3) == 0,
                       $urandom_range(0, 3) == 0, 13'($urandom), 13'($urandom));
      if (pick < 92) begin
         if ($urandom_range(0, 9) != 0) begin
            for (int k = 0; k < 8; k++) begin
               if (total_cnt[vc] != 0) break;
               vc = $urandom_range(0, 31);
            end
         end
         clp = (clp0_cnt[vc] != 0) ? 1'($urandom_range(0, 1)) : 1'b1;
         if ($urandom_range(0, 9) == 0) clp = 1'($urandom_range(0, 1));
         return mk_req(aca_epd_pkg::OP_DEPART, vc, clp, 1'($urandom_range(0, 1)),
                       13'($urandom), 13'($urandom));
      end
      if (pick < 98)
         return mk_req(aca_epd_pkg::OP_LIMIT, vc, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), rand_limit(), rand_limit());
      return mk_req(aca_epd_pkg::OP_NONE, vc, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 13'($urandom), 13'($urandom));
   endfunction

   task automatic send_item(aca_epd_pkg::req_type r, logic has_typed,
                            aca_epd_pkg::rsp_type t);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 6);
      repeat (gap) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data <= r;
      typed_valid <= has_typed;
      typed_rsp <= t;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   // leaves the write enable high; the caller lowers it after the last write
   task automatic write_reg(aca_epd_pkg::reg_type idx, logic [12:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      case (idx)
         aca_epd_pkg::REG_BUFFER_LIMIT: buf_limit = val[11:0];
         aca_epd_pkg::REG_EPD_THRESHOLD: epd_thr = val;
         aca_epd_pkg::REG_CLP1_THRESHOLD: clp1_thr = val;
         aca_epd_pkg::REG_EPD_FOR_CLP1: frame_clp1 = val[0];
         aca_epd_pkg::REG_FAIR_MODE: fair_mode = val[1:0];
         default: deliver_eof = val[0];
      endcase
      @(negedge clock);
   endtask

   // acceptance side: predict at the edge where the input item is taken
   always @(posedge clock) begin
      aca_epd_pkg::rsp_type p;
      if (!reset && req_if.valid && req_if.ready) begin
         p = admit_cell(aca_epd_pkg::req_type'(req_if.data));
         expected_rsp.push_back(typed_valid ? typed_rsp : p);
      end
   end

   always @(posedge clock) begin
      aca_epd_pkg::rsp_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = aca_epd_pkg::rsp_type'(rsp_if.data);
         if (expected_rsp.size() == 0) begin
            if (errors < 10) $display("unexpected result %p", got);
            errors++;
         end else begin
            want = expected_rsp.pop_front();
            if (got.accepted !== want.accepted || got.drop_cause !== want.drop_cause ||
                got.occupancy !== want.occupancy ||
                got.vc_queue_length !== want.vc_queue_length ||
                got.underflow_error !== want.underflow_error) begin
               if (errors < 10) $display("mismatch: expected %p got %p", want, got);
               errors++;
            end
         end
      end
   end

   // result side stalls
   initial begin
      int stall;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = burst ? 0 : $urandom_range(0, 6);
         repeat (stall) begin
            rsp_if.ready <= 1'b0;
            @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   typedef struct {
      aca_epd_pkg::req_type r;
      logic                 has_typed;
      aca_epd_pkg::rsp_type t;
   } stim_row;

   typedef struct {
      logic [12:0] v [6];
   } reg_set;

   initial begin
      stim_row rows [$];
      reg_set sets [$];
      reg_set s;
      req_if.valid = 1'b0;
      req_if.data = '0;
      buf_limit = 12'd4095;
      epd_thr = 13'd3072;
      clp1_thr = 13'd2048;
      frame_clp1 = 1'b0;
      fair_mode = 2'd0;
      deliver_eof = 1'b0;
      occ = '0;
      for (int i = 0; i < NumVc; i++) begin
         start_flag[i] = 1'b1;
         accept_flag[i] = 1'b0;
         total_cnt[i] = '0;
         clp0_cnt[i] = '0;
         frame_lim[i] = 13'd4095;
         clp1_lim[i] = 13'd4095;
      end

      rows.push_back('{mk_req(aca_epd_pkg::OP_DEPART, 0, 0, 0), 1,
                       mk_rsp(0, aca_epd_pkg::CauseNone, 0, 0, 1)});
      rows.push_back('{mk_req(aca_epd_pkg::OP_NONE, 5, 1, 1, 13'h1FFF, 13'h1FFF), 1,
                       mk_rsp(0, aca_epd_pkg::CauseNone, 0, 0, 0)});
      rows.push_back('{mk_req(aca_epd_pkg::OP_ARRIVE, 0, 0, 0), 1,
                       mk_rsp(1, aca_epd_pkg::CauseNone, 1, 1, 0)});
      rows.push_back('{mk_req(aca_epd_pkg::OP_ARRIVE, 0, 1, 1), 1,
                       mk_rsp(1, aca_epd_pkg::CauseNone, 2, 2, 0)});
      rows.push_back('{mk_req(aca_epd_pkg::OP_LIMIT, 1, 0, 0, 13'd0, 13'h1FFF), 1,
                       mk_rsp(0, aca_epd_pkg::CauseNone, 2, 0, 0)});
      // zero frame limit refuses the frame
      rows.push_back('{mk_req(aca_epd_pkg::OP_ARRIVE, 1, 0, 1), 1,
                       mk_rsp(0, aca_epd_pkg::CausePolicy, 2, 0, 0)});
      rows.push_back('{mk_req(aca_epd_pkg::OP_LIMIT, 2, 1, 1, 13'd4095, 13'd0), 1,
                       mk_rsp(0, aca_epd_pkg::CauseNone, 2, 0, 0)});
      rows.push_back('{mk_req(aca_epd_pkg::OP_ARRIVE, 2, 1, 0), 1,
                       mk_rsp(0, aca_epd_pkg::CausePolicy, 2, 0, 0)});
      // rest of a refused frame is dropped too
      rows.push_back('{mk_req(aca_epd_pkg::OP_ARRIVE, 2, 0, 1), 1,
                       mk_rsp(0, aca_epd_pkg::CausePolicy, 2, 0, 0)});
      rows.push_back('{mk_req(aca_epd_pkg::OP_LIMIT, 31, 0, 0, 13'h1FFF, 13'h1FFF), 1,
                       mk_rsp(0, aca_epd_pkg::CauseNone, 2, 0, 0)});
      rows.push_back('{mk_req(aca_epd_pkg::OP_ARRIVE, 31, 0, 1), 1,
                       mk_rsp(1, aca_epd_pkg::CauseNone, 3, 1, 0)});
      rows.push_back('{mk_req(aca_epd_pkg::OP_DEPART, 31, 1, 1), 1,
                       mk_rsp(0, aca_epd_pkg::CauseNone, 2, 0, 0)});
      rows.push_back('{mk_req(aca_epd_pkg::OP_DEPART, 0, 0, 0), 1,
                       mk_rsp(0, aca_epd_pkg::CauseNone, 1, 1, 0)});
      rows.push_back('{mk_req(aca_epd_pkg::OP_DEPART, 31, 0, 0), 0, '0});
      rows.push_back('{mk_req(aca_epd_pkg::OP_ARRIVE, 7, 1, 0, 13'h1FFF, 13'h1FFF), 0, '0});
      rows.push_back('{mk_req(aca_epd_pkg::OP_ARRIVE, 7, 0, 1), 0, '0});
      rows.push_back('{mk_req(aca_epd_pkg::OP_LIMIT, 16, 1, 0, 13'h0AAA, 13'h1555), 0, '0});
      rows.push_back('{mk_req(aca_epd_pkg::OP_LIMIT, 15, 0, 1, 13'h1555, 13'h0AAA), 0, '0});

      sets.push_back('{'{13'd48, 13'd40, 13'd24, 13'd0, 13'd1, 13'd0}});
      sets.push_back('{'{13'd48, 13'd40, 13'd24, 13'd1, 13'd2, 13'd1}});
      sets.push_back('{'{13'd30, 13'h1FFF, 13'd12, 13'd0, 13'd2, 13'd1}});
      sets.push_back('{'{13'd1, 13'd1, 13'd1, 13'd1, 13'd1, 13'd0}});
      sets.push_back('{'{13'd0, 13'd0, 13'd0, 13'd0, 13'd3, 13'd1}});
      sets.push_back('{'{13'd4095, 13'd4096, 13'd4096, 13'd0, 13'd0, 13'd1}});
      sets.push_back('{'{13'd60, 13'd50, 13'd10, 13'd0, 13'd2, 13'd0}});
      sets.push_back('{'{13'd20, 13'd16, 13'd15, 13'd1, 13'd1, 13'd0}});

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (rows[i]) send_item(rows[i].r, rows[i].has_typed, rows[i].t);
      typed_valid <= 1'b0;
      for (int n = 0; n < ItemsPerPhase; n++) send_item(rand_req(), 1'b0, '0);

      foreach (sets[p]) begin
         drain();
         s = sets[p];
         for (int k = 0; k < 6; k++) write_reg(aca_epd_pkg::reg_type'(k), s.v[k]);
         csr_write <= 1'b0;
         burst = (p % 3 == 2);
         for (int n = 0; n < ItemsPerPhase; n++) send_item(rand_req(), 1'b0, '0);
      end

      req_if.valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
+incdir+sv
sv/aca_epd_pkg.sv
sv/aca_stream_if.sv
sv/aca_epd_ctrl.sv
sv/aca_epd_dp.sv
sv/atm_cell_admission_epd_fba_core.sv
sv/aca_epd_checker.sv
dv/tb_atm_cell_admission_epd_fba_core.sv
